/* sv/tzs_pkg.sv */
// Shared types and constants for the thermal zone selector.
// No dependencies; imported by every module of the block.
package tzs_pkg;

  localparam int TEMP_W     = 19;
  localparam int ZONE_W     = 2;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int TRIP_REGS  = 4;
  localparam int MAX_ZONES  = 4;
  localparam int ZONE_CAP_I = (MAX_ZONES < TRIP_REGS) ? MAX_ZONES : TRIP_REGS;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef temp_t [TRIP_REGS-1:0]    trip_set_t;

  localparam temp_t TEMP_MIN   = -19'sd200000;
  localparam temp_t TEMP_MAX   = 19'sd200000;
  localparam temp_t TRIP_RESET = 19'sd200000;

  localparam logic [CNT_W-1:0] ZONE_CAP = CNT_W'(ZONE_CAP_I);

  localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_ZERO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_THREE = 3'd4;

endpackage

/* sv/thermal_zone_selector.sv */
// Top level of the thermal zone selector: configuration registers and the
// three-stage pipeline. Depends on tzs_pkg, tzs_window, tzs_average, tzs_classify.
//
//   channel   signals                                               direction
//   sample    sample_valid, sample_stall, sample_temp               in
//   result    result_valid, result_stall, ready_res .. zone_changed out
//   config    wr_en, wr_index, wr_data                              in
//
// One beat is accepted per cycle while sample_stall is low. A result is presented
// after the ring/sum, reciprocal multiply and zone compare stages, each of which
// adds one register. Each stage holds while the one after it is full and stalled,
// so a waiting result lets two more samples in before sample_stall rises. Reset
// clears the history ring, warm-up state, previous selection and the configuration
// registers.
module thermal_zone_selector #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  tzs_pkg::temp_t                     sample_temp,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               ready_res,
  output tzs_pkg::temp_t                     average_temp,
  output logic                               zone_found,
  output logic [tzs_pkg::ZONE_W-1:0]         zone_number,
  output logic                               zone_changed,
  input  logic                               wr_en,
  input  logic [tzs_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [tzs_pkg::CFG_DATA_W-1:0]     wr_data
);
  import tzs_pkg::*;

  localparam int SUM_W = TEMP_W + $clog2(WINDOW_LEN);

  logic [CNT_W-1:0]        zone_count;
  trip_set_t               trips;
  logic                    win_valid;
  logic                    win_stall;
  logic                    win_warm;
  logic signed [SUM_W-1:0] win_sum;
  logic                    avg_valid;
  logic                    avg_stall;
  logic                    avg_warm;
  temp_t                   avg_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_count <= '0;
      for (int i = 0; i < TRIP_REGS; i++) begin
        trips[i] <= TRIP_RESET;
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_ZONE_COUNT: begin
          zone_count <= wr_data[CNT_W-1:0];
        end
        REG_TRIP_ZERO: begin
          trips[0] <= temp_t'(wr_data);
        end
        REG_TRIP_ONE: begin
          trips[1] <= temp_t'(wr_data);
        end
        REG_TRIP_TWO: begin
          trips[2] <= temp_t'(wr_data);
        end
        REG_TRIP_THREE: begin
          trips[3] <= temp_t'(wr_data);
        end
        default: begin
        end
      endcase
    end
  end

  tzs_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_temp (sample_temp),
    .win_valid   (win_valid),
    .win_stall   (win_stall),
    .win_warm    (win_warm),
    .win_sum     (win_sum)
  );

  tzs_average #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_average (
    .clk      (clk),
    .rst      (rst),
    .win_valid(win_valid),
    .win_stall(win_stall),
    .win_warm (win_warm),
    .win_sum  (win_sum),
    .avg_valid(avg_valid),
    .avg_stall(avg_stall),
    .avg_warm (avg_warm),
    .avg_temp (avg_temp)
  );

  tzs_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .avg_valid   (avg_valid),
    .avg_stall   (avg_stall),
    .avg_warm    (avg_warm),
    .avg_temp    (avg_temp),
    .zone_count  (zone_count),
    .trips       (trips),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .ready_res   (ready_res),
    .average_temp(average_temp),
    .zone_found  (zone_found),
    .zone_number (zone_number),
    .zone_changed(zone_changed)
  );

endmodule

/* sv/tzs_window.sv */
// History ring with running sum and warm-up tracking; first pipeline stage.
// Depends on tzs_pkg.
module tzs_window #(
  parameter int WINDOW_LEN = 5,
  localparam int SUM_W = tzs_pkg::TEMP_W + $clog2(WINDOW_LEN)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  tzs_pkg::temp_t          sample_temp,
  output logic                    win_valid,
  input  logic                    win_stall,
  output logic                    win_warm,
  output logic signed [SUM_W-1:0] win_sum
);
  import tzs_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(WINDOW_LEN - 1);

  temp_t                    ring [WINDOW_LEN];
  logic [PTR_W-1:0]         wr_ptr;
  logic                     warming;
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  total_next;
  temp_t                    clamped;
  logic                     accept;

  assign sample_stall = win_valid & win_stall;
  assign accept       = sample_valid & ~sample_stall;

  always_comb begin
    if (sample_temp < TEMP_MIN) begin
      clamped = TEMP_MIN;
    end else if (sample_temp > TEMP_MAX) begin
      clamped = TEMP_MAX;
    end else begin
      clamped = sample_temp;
    end
  end

  assign total_next = total - SUM_W'(ring[wr_ptr]) + SUM_W'(clamped);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring[i] <= '0;
      end
      wr_ptr    <= '0;
      warming   <= 1'b1;
      total     <= '0;
      win_valid <= 1'b0;
    end else begin
      if (accept) begin
        ring[wr_ptr] <= clamped;
        wr_ptr       <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
        if (wr_ptr == LAST) begin
          warming <= 1'b0;
        end
        total    <= total_next;
        win_warm <= warming & (wr_ptr != LAST);
        win_sum  <= total_next;
      end
      if (accept) begin
        win_valid <= 1'b1;
      end else if (!win_stall) begin
        win_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/tzs_average.sv */
// Window average by reciprocal multiplication, truncated toward zero.
// Second pipeline stage; depends on tzs_pkg.
module tzs_average #(
  parameter int WINDOW_LEN = 5,
  localparam int SUM_W = tzs_pkg::TEMP_W + $clog2(WINDOW_LEN)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    win_valid,
  output logic                    win_stall,
  input  logic                    win_warm,
  input  logic signed [SUM_W-1:0] win_sum,
  output logic                    avg_valid,
  input  logic                    avg_stall,
  output logic                    avg_warm,
  output tzs_pkg::temp_t          avg_temp
);
  import tzs_pkg::*;

  localparam int MAG_W  = SUM_W - 1;
  localparam int SHIFT  = MAG_W + $clog2(WINDOW_LEN);
  localparam int PROD_W = MAG_W + SHIFT;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [SHIFT-1:0] RECIP = SHIFT'(RECIP_FULL);

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [TEMP_W-1:0] quot;
  temp_t             avg;
  logic              load;

  assign win_stall = avg_valid & avg_stall;
  assign load      = win_valid & ~win_stall;

  assign neg  = win_sum[SUM_W-1];
  assign mag  = neg ? MAG_W'(-win_sum) : MAG_W'(win_sum);
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);
  assign quot = TEMP_W'(prod[PROD_W-1:SHIFT]);
  assign avg  = neg ? temp_t'(-quot) : temp_t'(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else begin
      if (load) begin
        avg_warm <= win_warm;
        avg_temp <= avg;
      end
      if (load) begin
        avg_valid <= 1'b1;
      end else if (!avg_stall) begin
        avg_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/tzs_classify.sv */
// Zone selection against trip points, change detection and result register.
// Last pipeline stage; depends on tzs_pkg.
module tzs_classify (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             avg_valid,
  output logic                             avg_stall,
  input  logic                             avg_warm,
  input  tzs_pkg::temp_t                   avg_temp,
  input  logic [tzs_pkg::CNT_W-1:0]        zone_count,
  input  tzs_pkg::trip_set_t               trips,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             ready_res,
  output tzs_pkg::temp_t                   average_temp,
  output logic                             zone_found,
  output logic [tzs_pkg::ZONE_W-1:0]       zone_number,
  output logic                             zone_changed
);
  import tzs_pkg::*;

  logic              current_found;
  logic [ZONE_W-1:0] current_zone;
  logic [CNT_W-1:0]  limit;
  logic              found;
  logic [ZONE_W-1:0] zone;
  logic              changed;
  logic              load;

  assign avg_stall = result_valid & result_stall;
  assign load      = avg_valid & ~avg_stall;
  assign limit     = (zone_count > ZONE_CAP) ? ZONE_CAP : zone_count;

  always_comb begin
    found = 1'b0;
    zone  = '0;
    for (int i = 0; i < TRIP_REGS; i++) begin
      if ((CNT_W'(i) < limit) && (avg_temp >= $signed(trips[i]))) begin
        found = 1'b1;
        zone  = ZONE_W'(i);
      end
    end
  end

  assign changed = (found != current_found) ||
                   (found && current_found && (zone != current_zone));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      current_found <= 1'b0;
      current_zone  <= '0;
    end else begin
      if (load) begin
        if (avg_warm) begin
          ready_res    <= 1'b0;
          average_temp <= '0;
          zone_found   <= 1'b0;
          zone_number  <= '0;
          zone_changed <= 1'b0;
        end else begin
          ready_res     <= 1'b1;
          average_temp  <= avg_temp;
          zone_found    <= found;
          zone_number   <= zone;
          zone_changed  <= changed;
          current_found <= found;
          current_zone  <= zone;
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* tb/tzs_checker.sv */
// Scoreboard for the thermal zone selector: tracks register writes, predicts each
// result from the accepted sample beats and compares every result beat field by field.
// Depends on tzs_pkg.
module tzs_checker #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  input  logic                           sample_stall,
  input  tzs_pkg::temp_t                 sample_temp,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  logic                           ready_res,
  input  tzs_pkg::temp_t                 average_temp,
  input  logic                           zone_found,
  input  logic [tzs_pkg::ZONE_W-1:0]     zone_number,
  input  logic                           zone_changed,
  input  logic                           wr_en,
  input  logic [tzs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tzs_pkg::CFG_DATA_W-1:0] wr_data,
  output int                             fail_count,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tzs_pkg::*;

  typedef struct packed {
    logic              ready;
    temp_t             avg;
    logic              found;
    logic [ZONE_W-1:0] zone;
    logic              changed;
  } zone_report_t;

  temp_t             history [WINDOW_LEN];
  int                wr_pos;
  bit                warming;
  bit                sel_found;
  logic [ZONE_W-1:0] sel_zone;
  logic [CNT_W-1:0]  zones_used;
  temp_t             trip_pt [TRIP_REGS];
  zone_report_t      expected_reports [$];

  function automatic zone_report_t classify_sample(temp_t raw);
    zone_report_t rep;
    temp_t        t;
    int           total;
    int           avg;
    int           lim;
    rep = '0;
    t = (raw < TEMP_MIN) ? TEMP_MIN : ((raw > TEMP_MAX) ? TEMP_MAX : raw);
    history[wr_pos] = t;
    wr_pos = (wr_pos + 1) % WINDOW_LEN;
    if (warming) begin
      if (wr_pos != 0) return rep;
      warming = 1'b0;
    end
    total = 0;
    foreach (history[i]) total += int'(history[i]);
    avg = total / WINDOW_LEN;
    lim = int'(zones_used);
    if (lim > TRIP_REGS) lim = TRIP_REGS;
    if (lim > MAX_ZONES) lim = MAX_ZONES;
    for (int i = lim - 1; i >= 0; i--) begin
      if (avg >= int'(trip_pt[i])) begin
        rep.found = 1'b1;
        rep.zone  = ZONE_W'(i);
        break;
      end
    end
    rep.ready   = 1'b1;
    rep.avg     = temp_t'(avg);
    rep.changed = (rep.found != sel_found) ||
                  (rep.found && sel_found && rep.zone != sel_zone);
    sel_found = rep.found;
    sel_zone  = rep.found ? rep.zone : '0;
    return rep;
  endfunction

  function automatic int field_diff(string field, logic signed [31:0] want,
                                    logic signed [31:0] got);
    if (want === got) return 0;
    $error("%s: expected %0d, got %0d", field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    zone_report_t want;
    int           bad;
    if (rst) begin
      foreach (history[i]) history[i] = '0;
      foreach (trip_pt[i]) trip_pt[i] = TRIP_RESET;
      wr_pos     = 0;
      warming    = 1'b1;
      sel_found  = 1'b0;
      sel_zone   = '0;
      zones_used = '0;
      expected_reports.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      bad = 0;
      if (wr_en) begin
        case (wr_index)
          REG_ZONE_COUNT: zones_used = wr_data[CNT_W-1:0];
          REG_TRIP_ZERO:  trip_pt[0] = temp_t'(wr_data);
          REG_TRIP_ONE:   trip_pt[1] = temp_t'(wr_data);
          REG_TRIP_TWO:   trip_pt[2] = temp_t'(wr_data);
          REG_TRIP_THREE: trip_pt[3] = temp_t'(wr_data);
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with no prediction pending");
          bad = 1;
        end else begin
          want = expected_reports.pop_front();
          bad = field_diff("ready_res", want.ready, ready_res)
              + field_diff("average_temp", want.avg, average_temp)
              + field_diff("zone_found", want.found, zone_found)
              + field_diff("zone_number", want.zone, zone_number)
              + field_diff("zone_changed", want.changed, zone_changed);
        end
      end
      if (sample_valid && !sample_stall)
        expected_reports.push_back(classify_sample(sample_temp));
      fail_count  <= fail_count + bad;
      outstanding <= expected_reports.size();
    end
  end

endmodule

/* tb/tb_thermal_zone_selector.sv */
// Top of the thermal zone selector bench: clock, reset, register programming,
// bursty sample beats and a stalling result sink. Depends on tzs_pkg, tzs_checker
// and the thermal_zone_selector RTL.
module tb_thermal_zone_selector;
  timeunit 1ns;
  timeprecision 1ps;
  import tzs_pkg::*;

  localparam int WINDOW_LEN    = 5;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 105;

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  temp_t                 sample_temp;
  logic                  result_valid;
  logic                  result_stall;
  logic                  ready_res;
  temp_t                 average_temp;
  logic                  zone_found;
  logic [ZONE_W-1:0]     zone_number;
  logic                  zone_changed;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  int    fail_count;
  int    outstanding;
  int    beats_sent;
  int    burst_left;
  temp_t trip_seen [TRIP_REGS];

  thermal_zone_selector #(.WINDOW_LEN(WINDOW_LEN)) u_top (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_temp(sample_temp),
    .result_valid(result_valid), .result_stall(result_stall), .ready_res(ready_res),
    .average_temp(average_temp), .zone_found(zone_found), .zone_number(zone_number),
    .zone_changed(zone_changed),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  tzs_checker #(.WINDOW_LEN(WINDOW_LEN)) u_checker (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_temp(sample_temp),
    .result_valid(result_valid), .result_stall(result_stall), .ready_res(ready_res),
    .average_temp(average_temp), .zone_found(zone_found), .zone_number(zone_number),
    .zone_changed(zone_changed),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_sample(temp_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    sample_valid <= 1'b1;
    sample_temp  <= t;
    do @(posedge clk); while (sample_stall);
    burst_left--;
    beats_sent <= beats_sent + 1;
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    if (idx >= REG_TRIP_ZERO && idx <= REG_TRIP_THREE)
      trip_seen[idx - REG_TRIP_ZERO] = temp_t'(data);
    @(posedge clk);
  endtask

  function automatic int uniform_temp();
    return int'($urandom_range(0, 400000)) - 200000;
  endfunction

  task automatic program_zones(int phase);
    case (phase)
      0: begin
        write_reg(REG_ZONE_COUNT, CFG_DATA_W'(4));
        for (int i = 0; i < TRIP_REGS; i++)
          write_reg(CFG_IDX_W'(REG_TRIP_ZERO + i),
                    CFG_DATA_W'(-120000 + i * 80000 + int'($urandom_range(0, 40000)) - 20000));
      end
      1: begin
        write_reg(REG_ZONE_COUNT, CFG_DATA_W'(7));
        for (int i = 0; i < TRIP_REGS; i++)
          write_reg(CFG_IDX_W'(REG_TRIP_ZERO + i), CFG_DATA_W'(uniform_temp()));
        for (int k = TRIP_REGS + 1; k < 2 ** CFG_IDX_W; k++)
          write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
      end
      2: begin
        write_reg(REG_ZONE_COUNT, CFG_DATA_W'(2));
        write_reg(REG_TRIP_ZERO, {1'b1, {(CFG_DATA_W-1){1'b0}}});
        write_reg(REG_TRIP_ONE, {1'b0, {(CFG_DATA_W-1){1'b1}}});
        write_reg(REG_TRIP_TWO, CFG_DATA_W'(uniform_temp()));
        write_reg(REG_TRIP_THREE, CFG_DATA_W'(uniform_temp()));
      end
      3: begin
        write_reg(REG_ZONE_COUNT, CFG_DATA_W'(0));
        for (int i = 0; i < TRIP_REGS; i++)
          write_reg(CFG_IDX_W'(REG_TRIP_ZERO + i), CFG_DATA_W'(uniform_temp()));
      end
      4: begin
        write_reg(REG_ZONE_COUNT, CFG_DATA_W'(3));
        write_reg(REG_TRIP_ZERO, TEMP_MAX);
        write_reg(REG_TRIP_ONE, TEMP_MIN);
        write_reg(REG_TRIP_TWO, '0);
        write_reg(REG_TRIP_THREE, CFG_DATA_W'(uniform_temp()));
      end
      default: begin
        for (int k = 0; k < 2 ** CFG_IDX_W; k++)
          write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
      end
    endcase
    wr_en <= 1'b0;
  endtask

  function automatic int pick_level();
    int r;
    int lvl;
    r = $urandom_range(0, TRIP_REGS);
    if (r == TRIP_REGS) return uniform_temp();
    lvl = int'(trip_seen[r]) + int'($urandom_range(0, 6000)) - 3000;
    if (lvl > 255000) lvl = 255000;
    if (lvl < -255000) lvl = -255000;
    return lvl;
  endfunction

  function automatic temp_t near_level(int lvl);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return temp_t'($urandom);
    if (r < 30) return temp_t'(uniform_temp());
    return temp_t'(lvl + int'($urandom_range(0, 10000)) - 5000);
  endfunction

  // receiver: random stall patterns, plus long hold-offs while the sender keeps going
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int holds_done;
    result_stall <= 1'b0;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < 2 &&
          beats_sent >= ((holds_done == 0) ? 60 : 400)) begin
        hold_left = 80;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 9) < 7);
          default: result_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    int lvl;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample_temp  <= '0;
    wr_en        <= 1'b0;
    wr_index     <= '0;
    wr_data      <= '0;
    beats_sent   <= 0;
    burst_left = 0;
    foreach (trip_seen[i]) trip_seen[i] = TRIP_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // warm-up and clamping with reset registers
    send_sample(TEMP_MAX);
    send_sample(TEMP_MIN);
    send_sample(temp_t'(262143));
    send_sample(temp_t'(-262144));
    send_sample('0);
    send_sample(temp_t'(200001));
    send_sample(temp_t'(-200001));
    send_sample(temp_t'(-3));
    send_sample(temp_t'(-1));
    drain();

    // walk the average through every zone, including an exact trip hit
    write_reg(REG_ZONE_COUNT, CFG_DATA_W'(4));
    write_reg(REG_TRIP_ZERO, CFG_DATA_W'(-100000));
    write_reg(REG_TRIP_ONE, '0);
    write_reg(REG_TRIP_TWO, CFG_DATA_W'(50000));
    write_reg(REG_TRIP_THREE, CFG_DATA_W'(150000));
    wr_en <= 1'b0;
    repeat (5) send_sample(TEMP_MAX);
    repeat (5) send_sample(TEMP_MIN);
    repeat (5) send_sample('0);
    drain();

    lvl = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_zones(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 6 == 0) lvl = pick_level();
        send_sample(near_level(lvl));
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
